/* rtl/core/chf_pkg.sv */
// Shared constants, arctangent table and pipeline control type for the compass heading block.
package chf_pkg;

  // Width of the reading ports
  localparam int READING_PORT_W = 16;
  // Readings are scaled by 2^8 before rotation
  localparam int GUARD_SHIFT = 8;
  // Angle accumulator: signed, units of 2^-20 degree
  localparam int ANGLE_FRAC = 20;
  localparam int ANGLE_W = 31;
  // Result field width
  localparam int HEADING_W = 15;
  // Entries in the arctangent table
  localparam int TABLE_LEN = 24;

  localparam logic signed [ANGLE_W-1:0] DEG_0   = 31'sd0;
  localparam logic signed [ANGLE_W-1:0] DEG_180 = 31'sd188743680;
  localparam logic signed [ANGLE_W-1:0] DEG_360 = 31'sd377487360;

  // round(atan(2^-i) in degrees * 2^20)
  localparam logic signed [ANGLE_W-1:0] ATAN_DEG [TABLE_LEN] = '{
    31'sd47185920, 31'sd27855475, 31'sd14718068, 31'sd7471121,
    31'sd3750058,  31'sd1876857,  31'sd938658,   31'sd469357,
    31'sd234682,   31'sd117342,   31'sd58671,    31'sd29335,
    31'sd14668,    31'sd7334,     31'sd3667,     31'sd1833,
    31'sd917,      31'sd458,      31'sd229,      31'sd115,
    31'sd57,       31'sd29,       31'sd14,       31'sd7
  };

  // Control carried alongside each item down the chain
  typedef struct packed {
    logic valid;
    logic special;  // heading already exact, no rotation of the angle
  } chf_ctl_t;

endpackage

/* rtl/core/chf_prep.sv */
// Input stage: sign extension, quadrant fold, scaling and base angle selection.
module chf_prep #(
  parameter int READING_WIDTH = 16,
  parameter int DATA_W = 27
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      load,
  input  logic signed [chf_pkg::READING_PORT_W-1:0] x_reading,
  input  logic signed [chf_pkg::READING_PORT_W-1:0] y_reading,
  output logic signed [DATA_W-1:0]                  x_out,
  output logic signed [DATA_W-1:0]                  y_out,
  output logic signed [chf_pkg::ANGLE_W-1:0]        z_out,
  output chf_pkg::chf_ctl_t                         ctl_out
);

  logic signed [READING_WIDTH-1:0]    xr;
  logic signed [READING_WIDTH-1:0]    yr;
  logic signed [DATA_W-1:0]           xe;
  logic signed [DATA_W-1:0]           ye;
  logic signed [DATA_W-1:0]           x_next;
  logic signed [DATA_W-1:0]           y_next;
  logic signed [chf_pkg::ANGLE_W-1:0] z_next;
  logic                               special_next;

  // Only the low bits of each port carry the reading
  assign xr = x_reading[READING_WIDTH-1:0];
  assign yr = y_reading[READING_WIDTH-1:0];
  assign xe = DATA_W'(xr);
  assign ye = DATA_W'(yr);

  // Fold into the right half plane and pick the starting angle
  always_comb begin
    special_next = 1'b0;
    if (xr == '0 && yr == '0) begin
      special_next = 1'b1;
      z_next       = chf_pkg::DEG_180;
    end else if (yr == '0) begin
      special_next = 1'b1;
      z_next       = xr[READING_WIDTH-1] ? chf_pkg::DEG_360 : chf_pkg::DEG_180;
    end else if (xr[READING_WIDTH-1]) begin
      z_next = yr[READING_WIDTH-1] ? chf_pkg::DEG_0 : chf_pkg::DEG_360;
    end else begin
      z_next = chf_pkg::DEG_180;
    end
    if (xr[READING_WIDTH-1]) begin
      x_next = (-xe) <<< chf_pkg::GUARD_SHIFT;
      y_next = (-ye) <<< chf_pkg::GUARD_SHIFT;
    end else begin
      x_next = xe <<< chf_pkg::GUARD_SHIFT;
      y_next = ye <<< chf_pkg::GUARD_SHIFT;
    end
  end

  // Payload registers and valid flag
  always_ff @(posedge clk) begin
    x_out <= x_next;
    y_out <= y_next;
    z_out <= z_next;
    ctl_out.special <= special_next;
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= load;
    end
  end

endmodule

/* rtl/core/chf_cell.sv */
// One CORDIC vectoring cell: a single micro-rotation with its arctangent step.
module chf_cell #(
  parameter int DATA_W = 27,
  parameter int STAGE = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [DATA_W-1:0]           x_in,
  input  logic signed [DATA_W-1:0]           y_in,
  input  logic signed [chf_pkg::ANGLE_W-1:0] z_in,
  input  chf_pkg::chf_ctl_t                  ctl_in,
  output logic signed [DATA_W-1:0]           x_out,
  output logic signed [DATA_W-1:0]           y_out,
  output logic signed [chf_pkg::ANGLE_W-1:0] z_out,
  output chf_pkg::chf_ctl_t                  ctl_out
);

  localparam logic signed [chf_pkg::ANGLE_W-1:0] ATAN_STEP = chf_pkg::ATAN_DEG[STAGE];

  logic signed [DATA_W-1:0]           dx;
  logic signed [DATA_W-1:0]           dy;
  logic signed [DATA_W-1:0]           x_next;
  logic signed [DATA_W-1:0]           y_next;
  logic signed [chf_pkg::ANGLE_W-1:0] z_next;

  // Floor shifts of the cross terms
  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  // Rotate towards the X axis; the angle stays put on exact headings
  always_comb begin
    if (!y_in[DATA_W-1]) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      z_next = z_in + ATAN_STEP;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      z_next = z_in - ATAN_STEP;
    end
    if (ctl_in.special) begin
      z_next = z_in;
    end
  end

  // Payload registers and valid flag
  always_ff @(posedge clk) begin
    x_out <= x_next;
    y_out <= y_next;
    z_out <= z_next;
    ctl_out.special <= ctl_in.special;
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

endmodule

/* rtl/core/chf_round.sv */
// Output stage: clamp the angle to 0..360 degrees and round to the result format.
module chf_round #(
  parameter int FRACTION_BITS = 6
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [chf_pkg::ANGLE_W-1:0]  z_in,
  input  chf_pkg::chf_ctl_t                   ctl_in,
  output logic [chf_pkg::HEADING_W-1:0]       heading,
  output logic                                done
);

  localparam int SHIFT = chf_pkg::ANGLE_FRAC - FRACTION_BITS;
  localparam logic [chf_pkg::ANGLE_W:0] HALF_LSB = (chf_pkg::ANGLE_W + 1)'(1) << (SHIFT - 1);

  logic signed [chf_pkg::ANGLE_W-1:0] zc;
  logic [chf_pkg::ANGLE_W:0]          biased;
  logic [chf_pkg::ANGLE_W:0]          rounded;

  // Clamp residue past either end
  always_comb begin
    if (z_in[chf_pkg::ANGLE_W-1]) begin
      zc = chf_pkg::DEG_0;
    end else if (z_in > chf_pkg::DEG_360) begin
      zc = chf_pkg::DEG_360;
    end else begin
      zc = z_in;
    end
  end

  // Round to nearest, ties upward
  assign biased  = {1'b0, zc} + HALF_LSB;
  assign rounded = biased >> SHIFT;

  always_ff @(posedge clk) begin
    heading <= rounded[chf_pkg::HEADING_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
  end

endmodule

/* rtl/core/compass_heading_from_xy.sv */
// Top level: compass heading from X/Y magnetometer readings by a chain of CORDIC cells.
//
//   Channel   Ports                              Transfer when
//   input     start, busy, x_reading, y_reading  start high and busy low at a clock edge
//   result    done, heading                      done high for one cycle
//
// Registers along the path: one input register, one register per CORDIC cell and
// one clamp-and-round register. A new pair may be started every
// cycle; busy is always low since every cell hands its item on each cycle.
// Synchronous reset clears the valid flags along the chain; items in flight
// are dropped. The receiver cannot stall, so nothing holds back the chain.
module compass_heading_from_xy #(
  parameter int CORDIC_STAGES = 16,
  parameter int READING_WIDTH = 16,
  parameter int FRACTION_BITS = 6
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [chf_pkg::READING_PORT_W-1:0] x_reading,
  input  logic signed [chf_pkg::READING_PORT_W-1:0] y_reading,
  output logic                                      done,
  output logic [chf_pkg::HEADING_W-1:0]             heading
);

  // Folded magnitude up to 2^(RW-1), scaled by 2^8, CORDIC growth below 4
  localparam int DATA_W = READING_WIDTH + chf_pkg::GUARD_SHIFT + 3;
  localparam int LATENCY = CORDIC_STAGES + 2;
  localparam int HEADING_MAX = 360 << FRACTION_BITS;
  localparam logic [chf_pkg::HEADING_W-1:0] HEADING_HALF =
    chf_pkg::HEADING_W'(180 << FRACTION_BITS);

  logic signed [DATA_W-1:0]           xs [CORDIC_STAGES+1];
  logic signed [DATA_W-1:0]           ys [CORDIC_STAGES+1];
  logic signed [chf_pkg::ANGLE_W-1:0] zs [CORDIC_STAGES+1];
  chf_pkg::chf_ctl_t                  ctls [CORDIC_STAGES+1];

  assign busy = 1'b0;

  // Input stage
  chf_prep #(
    .READING_WIDTH (READING_WIDTH),
    .DATA_W        (DATA_W)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .load      (start && !busy),
    .x_reading (x_reading),
    .y_reading (y_reading),
    .x_out     (xs[0]),
    .y_out     (ys[0]),
    .z_out     (zs[0]),
    .ctl_out   (ctls[0])
  );

  // Chain of CORDIC cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    chf_cell #(
      .DATA_W (DATA_W),
      .STAGE  (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .x_in    (xs[i]),
      .y_in    (ys[i]),
      .z_in    (zs[i]),
      .ctl_in  (ctls[i]),
      .x_out   (xs[i+1]),
      .y_out   (ys[i+1]),
      .z_out   (zs[i+1]),
      .ctl_out (ctls[i+1])
    );
  end

  // Clamp and round
  chf_round #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_round (
    .clk     (clk),
    .rst     (rst),
    .z_in    (zs[CORDIC_STAGES]),
    .ctl_in  (ctls[CORDIC_STAGES]),
    .heading (heading),
    .done    (done)
  );

  // Every accepted pair produces a result after the fixed latency
  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("result missing after accepted pair");

  // No result without a pair accepted the latency earlier
  a_done_has_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without accepted pair");

  // Heading never exceeds 360 degrees when it fits the field
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    done && (FRACTION_BITS <= 6) |-> int'(heading) <= HEADING_MAX)
    else $error("heading out of range");

  // Zero Y with non-negative X is exactly 180 degrees
  a_axis_heading: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (y_reading[READING_WIDTH-1:0] == '0)
      && !x_reading[READING_WIDTH-1] && (FRACTION_BITS <= 6)
      |-> ##LATENCY heading == HEADING_HALF)
    else $error("axis heading not exact");

endmodule

/* sim/compass_heading_from_xy_tb.sv */
// Self-checking testbench for the CORDIC compass heading block: directed and random reading pairs.
module compass_heading_from_xy_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES        = 16;
  localparam int READING_BITS  = 16;
  localparam int FRAC_BITS     = 6;
  localparam int ANGLE_FRAC    = 20;
  localparam int PIPE_LATENCY  = STAGES + 2;
  localparam int MAX_REPORTS   = 10;

  typedef logic signed [chf_pkg::READING_PORT_W-1:0] reading_t;
  typedef logic [chf_pkg::HEADING_W-1:0]             heading_t;

  // One outstanding heading, with the readings that produced it
  typedef struct {
    reading_t x;
    reading_t y;
    heading_t heading;
  } heading_entry_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  reading_t x_reading;
  reading_t y_reading;
  logic     done;
  heading_t heading;

  heading_entry_t pending_headings[$];
  int             mismatch_count;
  bit             gaps_enabled;

  compass_heading_from_xy #(
    .CORDIC_STAGES(STAGES),
    .READING_WIDTH(READING_BITS),
    .FRACTION_BITS(FRAC_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .x_reading(x_reading),
    .y_reading(y_reading),
    .done(done),
    .heading(heading)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round(atan(2^-i) in degrees * 2^20)
  function automatic longint arctan_units(input int i);
    case (i)
      0:  return 47185920;
      1:  return 27855475;
      2:  return 14718068;
      3:  return 7471121;
      4:  return 3750058;
      5:  return 1876857;
      6:  return 938658;
      7:  return 469357;
      8:  return 234682;
      9:  return 117342;
      10: return 58671;
      11: return 29335;
      12: return 14668;
      13: return 7334;
      14: return 3667;
      15: return 1833;
      16: return 917;
      17: return 458;
      18: return 229;
      19: return 115;
      20: return 57;
      21: return 29;
      22: return 14;
      default: return 7;
    endcase
  endfunction

  // Heading in 1/64 degree from one reading pair, by CORDIC vectoring
  function automatic heading_t predict_heading(input reading_t xr, input reading_t yr);
    longint px;
    longint py;
    longint base;
    longint angle;
    longint step_x;
    longint step_y;
    longint full_turn;
    longint rounded;
    int     sh;
    full_turn = longint'(360) <<< ANGLE_FRAC;
    px = longint'(xr);
    py = longint'(yr);
    angle = 0;
    if (px == 0 && py == 0) return heading_t'(longint'(180) << FRAC_BITS);
    if (py == 0) return heading_t'(longint'(px > 0 ? 180 : 360) << FRAC_BITS);
    // Left half-plane: fold over, pick the base angle by the sign of Y
    if (px < 0) begin
      base = (py >= 0) ? full_turn : 0;
      px = -px;
      py = -py;
    end else begin
      base = longint'(180) <<< ANGLE_FRAC;
    end
    px = px * 256;
    py = py * 256;
    for (int i = 0; i < STAGES && i < 24; i++) begin
      step_x = py >>> i;
      step_y = px >>> i;
      if (py >= 0) begin
        px = px + step_x;
        py = py - step_y;
        angle = angle + arctan_units(i);
      end else begin
        px = px - step_x;
        py = py + step_y;
        angle = angle - arctan_units(i);
      end
    end
    angle = base + angle;
    if (angle < 0) angle = 0;
    if (angle > full_turn) angle = full_turn;
    sh = ANGLE_FRAC - FRAC_BITS;
    rounded = (angle + (longint'(1) << (sh - 1))) >> sh;
    return heading_t'(rounded);
  endfunction

  // Offer one pair from a falling edge; returns at a falling edge after the transfer and after any idle burst
  task automatic send_reading(input reading_t xv, input reading_t yv);
    heading_entry_t entry;
    start     = 1'b1;
    x_reading = xv;
    y_reading = yv;
    do @(posedge clk); while (busy);
    entry.x       = xv;
    entry.y       = yv;
    entry.heading = predict_heading(xv, yv);
    pending_headings.push_back(entry);
    @(negedge clk);
    // occasional idle burst on the sending side
    if (gaps_enabled && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic wait_until_drained();
    start = 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic reading_t small_reading(input int span);
    return reading_t'($urandom_range(0, 2 * span) - span);
  endfunction

  // Zero vector, both axes, the four diagonals, range extremes and clamp corners
  task automatic test_directed_cases();
    send_reading(16'sd0, 16'sd0);
    send_reading(16'sd1, 16'sd0);
    send_reading(-16'sd1, 16'sd0);
    send_reading(16'sh7fff, 16'sd0);
    send_reading(16'sh8000, 16'sd0);
    send_reading(16'sd0, 16'sd1);
    send_reading(16'sd0, -16'sd1);
    send_reading(16'sd0, 16'sh7fff);
    send_reading(16'sd0, 16'sh8000);
    send_reading(16'sd1, 16'sd1);
    send_reading(-16'sd1, 16'sd1);
    send_reading(-16'sd1, -16'sd1);
    send_reading(16'sd1, -16'sd1);
    send_reading(16'sh7fff, 16'sh7fff);
    send_reading(16'sh8000, 16'sh8000);
    send_reading(16'sh8000, 16'sh7fff);
    send_reading(16'sh7fff, 16'sh8000);
    // residue just either side of the X axis, negative and positive
    send_reading(16'sh8000, 16'sd1);
    send_reading(16'sh8000, -16'sd1);
    send_reading(16'sh7fff, 16'sd1);
    send_reading(16'sh7fff, -16'sd1);
    send_reading(-16'sd12345, 16'sd321);
    send_reading(-16'sd12345, -16'sd321);
  endtask

  task automatic test_random_full_range(input int count);
    for (int n = 0; n < count; n++)
      send_reading(reading_t'($urandom), reading_t'($urandom));
  endtask

  task automatic test_random_small_vectors(input int count);
    int span;
    for (int n = 0; n < count; n++) begin
      span = (n % 2 == 0) ? 8 : 300;
      send_reading(small_reading(span), small_reading(span));
    end
  endtask

  // One component near zero: exact-axis and clamp behaviour
  task automatic test_near_axes(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0)
        send_reading(reading_t'($urandom), small_reading(3));
      else
        send_reading(small_reading(3), reading_t'($urandom));
    end
  endtask

  // Let the pipeline empty completely, then resume
  task automatic test_drain_pause();
    test_random_full_range(20);
    wait_until_drained();
    test_random_full_range(20);
  endtask

  // Back-to-back transfers every cycle, no gaps
  task automatic test_back_to_back(input int count);
    gaps_enabled = 1'b0;
    test_random_full_range(count);
  endtask

  // Result checker
  always @(posedge clk) begin : heading_check
    heading_entry_t want;
    if (!rst && done) begin
      if (pending_headings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected heading %0d with nothing outstanding", heading);
      end else begin
        want = pending_headings.pop_front();
        if (heading !== want.heading) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("heading mismatch: x=%0d y=%0d expected %0d got %0d",
                     want.x, want.y, want.heading, heading);
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    x_reading      = '0;
    y_reading      = '0;
    mismatch_count = 0;
    gaps_enabled   = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_full_range(650);
    test_drain_pause();
    test_random_small_vectors(400);
    test_near_axes(300);
    test_back_to_back(350);

    wait_until_drained();
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0)
      $display("compass_heading_from_xy test passed");
    else
      $display("compass_heading_from_xy test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("compass_heading_from_xy test failed");
    $finish;
  end

endmodule
